FILE: rtl/bpr_pkg.sv
// Package for the banked palette rotator.
// Holds field widths, operation and command codes, and the queued command type.
// No dependencies.
`default_nettype none

package bpr_pkg;

  localparam int OP_W    = 2;
  localparam int BANK_W  = 3;
  localparam int IDX_W   = 8;
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 3 * CHAN_W;

  // Operation codes on the input channel
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_ROT_R  = 2'd1;
  localparam logic [OP_W-1:0] OP_ROT_L  = 2'd2;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd3;

  // Command kinds between front and back
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_ROTATE = 2'd1;
  localparam logic [1:0] CMD_COPY   = 2'd2;
  localparam logic [1:0] CMD_LOOKUP = 2'd3;

  localparam int CMD_DEPTH = 2;

  // idx_a: write/lookup entry, first rotate address, or copy source.
  // idx_b: rotate step count, or copy destination.
  typedef struct packed {
    logic [1:0]         kind;
    logic [BANK_W-1:0]  bank;
    logic [IDX_W-1:0]   idx_a;
    logic [IDX_W-1:0]   idx_b;
    logic               step_up;
    logic               blank;
    logic [COLOR_W-1:0] color;
  } bpr_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/bpr_in_if.sv
// Input channel of the palette rotator: valid/ready plus one request.
// Depends on bpr_pkg for field widths.
`default_nettype none

interface bpr_in_if;
  import bpr_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BANK_W-1:0] bank;
  logic [IDX_W-1:0]  first_index;
  logic [IDX_W-1:0]  last_index;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;

  modport source (
    output valid, operation, bank, first_index, last_index, red_in, green_in, blue_in,
    input  ready
  );

  modport sink (
    input  valid, operation, bank, first_index, last_index, red_in, green_in, blue_in,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/bpr_out_if.sv
// Result channel of the palette rotator: valid/ready plus one looked-up color.
// Depends on bpr_pkg for field widths.
`default_nettype none

interface bpr_out_if;
  import bpr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;

  modport source (
    output valid, red_out, green_out, blue_out,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/bpr_front.sv
// Front end: accepts requests, holds the active bank register, checks ranges
// and queues a command per passing request. Depends on bpr_pkg, bpr_in_if.
`default_nettype none

module bpr_front #(
  parameter int BANK_COUNT   = 8,
  parameter int BANK_ENTRIES = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  bpr_in_if.sink                      in_chan,
  input  wire logic                   cfg_we,
  input  wire logic [bpr_pkg::BANK_W-1:0] cfg_wdata,
  input  wire logic                   clearing,
  input  wire logic                   q_full,
  output logic                        q_push,
  output bpr_pkg::bpr_cmd_t           q_cmd
);
  import bpr_pkg::*;

  localparam logic [8:0] BANK_LIM  = 9'(BANK_COUNT);
  localparam logic [8:0] ENTRY_LIM = 9'(BANK_ENTRIES);

  logic [BANK_W-1:0] active_bank_r;
  logic              accept;
  logic              bank_ok;
  logic              act_ok;
  logic              first_ok;
  logic              last_ok;
  logic              keep;
  logic [IDX_W-1:0]  first;
  logic [IDX_W-1:0]  last;
  logic              right;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_bank_r <= '0;
    end else if (cfg_we) begin
      active_bank_r <= cfg_wdata;
    end
  end

  assign in_chan.ready = !q_full && !clearing;
  assign accept        = in_chan.valid && in_chan.ready;

  assign first    = in_chan.first_index;
  assign last     = in_chan.last_index;
  assign right    = (in_chan.operation == OP_ROT_R);
  assign bank_ok  = {6'b0, in_chan.bank} < BANK_LIM;
  assign act_ok   = {6'b0, active_bank_r} < BANK_LIM;
  assign first_ok = {1'b0, first} < ENTRY_LIM;
  assign last_ok  = {1'b0, last} < ENTRY_LIM;

  always_comb begin
    q_cmd       = '0;
    q_cmd.bank  = in_chan.bank;
    q_cmd.color = {in_chan.red_in, in_chan.green_in, in_chan.blue_in};
    keep        = 1'b0;
    unique case (in_chan.operation)
      OP_LOOKUP: begin
        q_cmd.kind  = CMD_LOOKUP;
        q_cmd.bank  = active_bank_r;
        q_cmd.idx_a = first;
        q_cmd.blank = !(act_ok && first_ok);
        keep        = 1'b1;
      end
      OP_WRITE: begin
        q_cmd.kind  = CMD_WRITE;
        q_cmd.idx_a = first;
        keep        = bank_ok && first_ok;
      end
      OP_ROT_R, OP_ROT_L: begin
        keep = bank_ok && first_ok && last_ok && (first != last);
        if (first < last) begin
          // walk from the wrapping entry toward the other end
          q_cmd.kind    = CMD_ROTATE;
          q_cmd.idx_a   = right ? last : first;
          q_cmd.idx_b   = last - first;
          q_cmd.step_up = !right;
        end else begin
          // reversed range degenerates to a single copy
          q_cmd.kind  = CMD_COPY;
          q_cmd.idx_a = right ? last : first;
          q_cmd.idx_b = right ? first : last;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = accept && keep;

endmodule

`default_nettype wire

FILE: rtl/bpr_cmd_fifo.sv
// Short command queue between the front and back of the palette rotator.
// Depends on bpr_pkg for the command type and depth.
`default_nettype none

module bpr_cmd_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire bpr_pkg::bpr_cmd_t  push_cmd,
  output logic                    full,
  output logic                    head_valid,
  output bpr_pkg::bpr_cmd_t       head_cmd,
  input  wire logic               pop
);
  import bpr_pkg::*;

  localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CW = $clog2(CMD_DEPTH + 1);

  bpr_cmd_t        slot_r [CMD_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW-1:0]   rd_ptr_nxt;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full       = (count_r == CW'(CMD_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bpr_back.sv
// Back end: palette memory, clearing pass, write/rotate/copy sequencer and
// the lookup output register. Depends on bpr_pkg and bpr_out_if.
`default_nettype none

module bpr_back #(
  parameter int BANK_COUNT   = 8,
  parameter int BANK_ENTRIES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmd_valid,
  input  wire bpr_pkg::bpr_cmd_t  cmd,
  output logic                    cmd_pop,
  output logic                    clearing,
  bpr_out_if.source               out_chan
);
  import bpr_pkg::*;

  localparam int ENTRY_BITS = (BANK_ENTRIES > 1) ? $clog2(BANK_ENTRIES) : 1;
  localparam int MEM_DEPTH  = BANK_COUNT << ENTRY_BITS;
  localparam int AW         = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_ROT     = 3'd2;
  localparam logic [2:0] ST_ROT_END = 3'd3;
  localparam logic [2:0] ST_COPY    = 3'd4;
  localparam logic [2:0] ST_LOOK    = 3'd5;

  logic [COLOR_W-1:0] mem [MEM_DEPTH];
  logic [COLOR_W-1:0] mem_q_r;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [COLOR_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;

  logic [2:0]         state_r, state_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] out_color_r, out_color_nxt;

  logic [BANK_W-1:0]  bank_r, bank_nxt;
  logic [IDX_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [IDX_W-1:0]   rd_left_r, rd_left_nxt;
  logic [IDX_W-1:0]   dq_ptr_r, dq_ptr_nxt;
  logic [IDX_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic               dq_first_r, dq_first_nxt;
  logic               step_up_r, step_up_nxt;
  logic               blank_r, blank_nxt;
  logic [COLOR_W-1:0] held_r, held_nxt;

  function automatic logic [AW-1:0] addr_of(input logic [BANK_W-1:0] b,
                                            input logic [IDX_W-1:0] i);
    addr_of = (AW'(b) << ENTRY_BITS) | AW'(i);
  endfunction

  function automatic logic [IDX_W-1:0] step(input logic [IDX_W-1:0] p, input logic up);
    step = up ? p + 8'd1 : p - 8'd1;
  endfunction

  assign clearing           = (state_r == ST_CLEAR);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.red_out   = out_color_r[3*CHAN_W-1:2*CHAN_W];
  assign out_chan.green_out = out_color_r[2*CHAN_W-1:CHAN_W];
  assign out_chan.blue_out  = out_color_r[CHAN_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_color_nxt = out_color_r;
    bank_nxt      = bank_r;
    rd_ptr_nxt    = rd_ptr_r;
    rd_left_nxt   = rd_left_r;
    dq_ptr_nxt    = dq_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    dq_first_nxt  = dq_first_r;
    step_up_nxt   = step_up_r;
    blank_nxt     = blank_r;
    held_nxt      = held_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_of(bank_r, wr_ptr_r);
    mem_wdata     = mem_q_r;
    mem_re        = 1'b0;
    mem_raddr     = addr_of(bank_r, rd_ptr_r);
    cmd_pop       = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MEM_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          bank_nxt = cmd.bank;
          unique case (cmd.kind)
            CMD_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = addr_of(cmd.bank, cmd.idx_a);
              mem_wdata = cmd.color;
            end
            CMD_ROTATE: begin
              mem_re       = 1'b1;
              mem_raddr    = addr_of(cmd.bank, cmd.idx_a);
              dq_ptr_nxt   = cmd.idx_a;
              dq_first_nxt = 1'b1;
              rd_ptr_nxt   = step(cmd.idx_a, cmd.step_up);
              rd_left_nxt  = cmd.idx_b;
              step_up_nxt  = cmd.step_up;
              state_nxt    = ST_ROT;
            end
            CMD_COPY: begin
              mem_re     = 1'b1;
              mem_raddr  = addr_of(cmd.bank, cmd.idx_a);
              wr_ptr_nxt = cmd.idx_b;
              state_nxt  = ST_COPY;
            end
            CMD_LOOKUP: begin
              // skip the read when the entry lies outside the store
              mem_re    = !cmd.blank;
              mem_raddr = addr_of(cmd.bank, cmd.idx_a);
              blank_nxt = cmd.blank;
              state_nxt = ST_LOOK;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_ROT: begin
        // mem_q_r holds the entry at dq_ptr_r; it moves to the entry read before it
        if (dq_first_r) begin
          held_nxt = mem_q_r;
        end else begin
          mem_we = 1'b1;
        end
        wr_ptr_nxt   = dq_ptr_r;
        dq_first_nxt = 1'b0;
        if (rd_left_r != '0) begin
          mem_re      = 1'b1;
          dq_ptr_nxt  = rd_ptr_r;
          rd_ptr_nxt  = step(rd_ptr_r, step_up_r);
          rd_left_nxt = rd_left_r - 8'd1;
        end else begin
          state_nxt = ST_ROT_END;
        end
      end
      ST_ROT_END: begin
        // wrap the held entry into the far end
        mem_we    = 1'b1;
        mem_wdata = held_r;
        state_nxt = ST_IDLE;
      end
      ST_COPY: begin
        mem_we    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_LOOK: begin
        // hold until the output register is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_color_nxt = blank_r ? '0 : mem_q_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_color_r <= out_color_nxt;
    bank_r      <= bank_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    rd_left_r   <= rd_left_nxt;
    dq_ptr_r    <= dq_ptr_nxt;
    wr_ptr_r    <= wr_ptr_nxt;
    dq_first_r  <= dq_first_nxt;
    step_up_r   <= step_up_nxt;
    blank_r     <= blank_nxt;
    held_r      <= held_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/banked_palette_rotator.sv
// Top level of the banked palette rotator: front end, command queue, back end.
// Depends on bpr_pkg, bpr_in_if, bpr_out_if, bpr_front, bpr_cmd_fifo, bpr_back.
//
//   port       dir   handshake      carries
//   in_chan    in    valid/ready    operation, bank, first/last index, color
//   out_chan   out   valid/ready    red/green/blue of a looked-up entry
//   cfg_*      in    cfg_we         active_bank
//
// A write is done in the back end's idle state, a copy adds the copy state, a lookup
// adds the look state and any wait on the output register, and a rotate over n+1
// entries passes the rotate state once per entry, then the rotate end state, paced by
// the single read and write port of the memory. After reset the back end clears all
// BANK_COUNT * 2**ceil(log2(BANK_ENTRIES)) entries to black, one entry a cycle, while
// in_chan.ready stays low. The queue takes up to two commands while a rotate runs.
`default_nettype none

module banked_palette_rotator #(
  parameter int BANK_COUNT   = 8,
  parameter int BANK_ENTRIES = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  bpr_in_if.sink                          in_chan,
  bpr_out_if.source                       out_chan,
  input  wire logic                       cfg_we,
  input  wire logic [bpr_pkg::BANK_W-1:0] cfg_wdata
);
  import bpr_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  logic     clearing;
  bpr_cmd_t q_cmd_in;
  bpr_cmd_t q_cmd_out;

  bpr_front #(
    .BANK_COUNT   (BANK_COUNT),
    .BANK_ENTRIES (BANK_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd_in)
  );

  bpr_cmd_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd_in),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (q_cmd_out),
    .pop        (q_pop)
  );

  bpr_back #(
    .BANK_COUNT   (BANK_COUNT),
    .BANK_ENTRIES (BANK_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_cmd_out),
    .cmd_pop   (q_pop),
    .clearing  (clearing),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

FILE: bench/banked_palette_rotator_test.sv
// Self-checking bench for banked_palette_rotator: directed table plus random phases.
// Depends on bpr_pkg, bpr_in_if, bpr_out_if and the banked_palette_rotator RTL.
`default_nettype none

module banked_palette_rotator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bpr_pkg::*;

  localparam int NUM_BANKS       = 8;
  localparam int BANK_DEPTH      = 256;
  localparam int ITEMS_PER_PHASE = 310;
  localparam int QUIET_CYCLES    = 800;    // two queued full rotates plus one running
  localparam int STALL_LIMIT     = 20000;  // covers the clearing pass after reset

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BANK_W-1:0] bank;
    logic [IDX_W-1:0]  first;
    logic [IDX_W-1:0]  last;
    rgb_t              color;
  } palette_req_t;

  typedef struct packed {
    palette_req_t req;
    logic         typed;
    rgb_t         typed_color;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam directed_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    '{'{OP_LOOKUP, 3'd7, 8'd0,   8'd255, 24'hFFFFFF}, 1'b1, 24'h000000},
    '{'{OP_LOOKUP, 3'd0, 8'd255, 8'd0,   24'h000000}, 1'b1, 24'h000000},
    '{'{OP_WRITE,  3'd0, 8'd0,   8'd255, 24'hFFFFFF}, 1'b0, 24'h000000},
    '{'{OP_WRITE,  3'd0, 8'd255, 8'd0,   24'h00FF00}, 1'b0, 24'h000000},
    '{'{OP_LOOKUP, 3'd3, 8'd0,   8'd0,   24'h000000}, 1'b1, 24'hFFFFFF},
    '{'{OP_WRITE,  3'd7, 8'd255, 8'd0,   24'hAA55C3}, 1'b0, 24'h000000},
    '{'{OP_LOOKUP, 3'd7, 8'd255, 8'd0,   24'h000000}, 1'b1, 24'h00FF00},
    '{'{OP_WRITE,  3'd0, 8'd1,   8'd200, 24'h010203}, 1'b0, 24'h000000},
    '{'{OP_WRITE,  3'd0, 8'd2,   8'd0,   24'h804020}, 1'b0, 24'h000000},
    '{'{OP_ROT_R,  3'd0, 8'd0,   8'd2,   24'hFFFFFF}, 1'b0, 24'h000000},
    '{'{OP_LOOKUP, 3'd0, 8'd0,   8'd0,   24'h000000}, 1'b0, 24'h000000},
    '{'{OP_LOOKUP, 3'd0, 8'd2,   8'd0,   24'h000000}, 1'b0, 24'h000000},
    '{'{OP_ROT_L,  3'd0, 8'd0,   8'd2,   24'h000000}, 1'b0, 24'h000000},
    '{'{OP_ROT_R,  3'd0, 8'd2,   8'd2,   24'h000000}, 1'b0, 24'h000000},
    '{'{OP_ROT_R,  3'd0, 8'd2,   8'd0,   24'h000000}, 1'b0, 24'h000000},
    '{'{OP_ROT_L,  3'd0, 8'd1,   8'd0,   24'h000000}, 1'b0, 24'h000000},
    '{'{OP_LOOKUP, 3'd0, 8'd0,   8'd0,   24'h000000}, 1'b0, 24'h000000},
    '{'{OP_LOOKUP, 3'd0, 8'd1,   8'd0,   24'h000000}, 1'b0, 24'h000000},
    '{'{OP_LOOKUP, 3'd0, 8'd2,   8'd0,   24'h000000}, 1'b0, 24'h000000},
    '{'{OP_ROT_L,  3'd0, 8'd0,   8'd255, 24'h000000}, 1'b0, 24'h000000},
    '{'{OP_LOOKUP, 3'd0, 8'd255, 8'd0,   24'h000000}, 1'b0, 24'h000000},
    '{'{OP_LOOKUP, 3'd0, 8'd254, 8'd0,   24'h000000}, 1'b0, 24'h000000},
    '{'{OP_ROT_R,  3'd7, 8'd0,   8'd255, 24'h000000}, 1'b0, 24'h000000},
    '{'{OP_ROT_L,  3'd5, 8'd255, 8'd0,   24'h000000}, 1'b0, 24'h000000},
    '{'{OP_LOOKUP, 3'd0, 8'd1,   8'd0,   24'h000000}, 1'b0, 24'h000000}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [BANK_W-1:0]   cfg_wdata;

  bpr_in_if  in_chan ();
  bpr_out_if out_chan ();

  banked_palette_rotator #(
    .BANK_COUNT   (NUM_BANKS),
    .BANK_ENTRIES (BANK_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow palette and register
  rgb_t              palette_model [NUM_BANKS][BANK_DEPTH];
  logic [BANK_W-1:0] active_bank_model;
  rgb_t              pending_colors [$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  window_base;
  bit  request_held;
  int  fail_count;
  int  requests_sent;
  int  rotates_sent;
  int  colors_checked;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one accepted request to the shadow palette; lookups yield a color
  task automatic palette_apply(input palette_req_t r, output bit gives_color,
                               output rgb_t color);
    rgb_t held;
    int   lo;
    int   hi;
    gives_color = 1'b0;
    color       = '0;
    lo          = int'(r.first);
    hi          = int'(r.last);
    if (r.op == OP_LOOKUP) begin
      gives_color = 1'b1;
      if (active_bank_model < NUM_BANKS && lo < BANK_DEPTH)
        color = palette_model[active_bank_model][lo];
    end else if (r.bank < NUM_BANKS) begin
      if (r.op == OP_WRITE) begin
        if (lo < BANK_DEPTH) palette_model[r.bank][lo] = r.color;
      end else if (lo < BANK_DEPTH && hi < BANK_DEPTH) begin
        // start above end leaves the loop empty: only the wrap copy happens
        if (r.op == OP_ROT_R) begin
          held = palette_model[r.bank][hi];
          for (int i = hi; i > lo; i--) palette_model[r.bank][i] = palette_model[r.bank][i-1];
          palette_model[r.bank][lo] = held;
        end else begin
          held = palette_model[r.bank][lo];
          for (int i = lo; i < hi; i++) palette_model[r.bank][i] = palette_model[r.bank][i+1];
          palette_model[r.bank][hi] = held;
        end
      end
    end
  endtask

  task automatic send_request(input palette_req_t r, input bit typed, input rgb_t typed_color);
    bit   gives_color;
    rgb_t color;
    in_chan.valid       <= 1'b1;
    in_chan.operation   <= r.op;
    in_chan.bank        <= r.bank;
    in_chan.first_index <= r.first;
    in_chan.last_index  <= r.last;
    in_chan.red_in      <= r.color.red;
    in_chan.green_in    <= r.color.green;
    in_chan.blue_in     <= r.color.blue;
    do @(posedge clk); while (!in_chan.ready);
    palette_apply(r, gives_color, color);
    if (gives_color) pending_colors.push_back(typed ? typed_color : color);
    requests_sent++;
    if (r.op == OP_ROT_R || r.op == OP_ROT_L) rotates_sent++;
    // hold off the next request now and then
    if ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      request_held = 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end else begin
      request_held = 1'b1;
    end
  endtask

  // Drop valid, wait for every lookup, then let queued rotates finish
  task automatic wait_quiet();
    if (request_held) begin
      in_chan.valid <= 1'b0;
      request_held = 1'b0;
    end
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_active_bank(input logic [BANK_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_bank_model = value;
  endtask

  function automatic palette_req_t random_request();
    palette_req_t r;
    int           pick;
    int           span;
    pick = $urandom_range(99);
    r.op = (pick < 35) ? OP_WRITE : (pick < 55) ? OP_ROT_R : (pick < 75) ? OP_ROT_L : OP_LOOKUP;
    r.bank        = ($urandom_range(99) < 70) ? active_bank_model : BANK_W'($urandom_range(7));
    r.first       = ($urandom_range(99) < 75) ? IDX_W'(window_base + $urandom_range(31))
                                              : IDX_W'($urandom_range(255));
    r.last        = IDX_W'($urandom_range(255));
    r.color.red   = CHAN_W'($urandom_range(255));
    r.color.green = CHAN_W'($urandom_range(255));
    r.color.blue  = CHAN_W'($urandom_range(255));
    if (r.op == OP_ROT_R || r.op == OP_ROT_L) begin
      // keep most rotates short; a few span the whole bank
      pick = $urandom_range(99);
      if (pick < 3) begin
        r.first = '0;
        r.last  = '1;
      end else if (pick < 13) begin
        r.last = IDX_W'($urandom_range(r.first));
      end else if (pick < 18) begin
        r.last = r.first;
      end else begin
        span   = $urandom_range(1, 12);
        r.last = (r.first + span > 255) ? 8'd255 : IDX_W'(r.first + span);
      end
    end
    return r;
  endfunction

  // Result side: check each color against the oldest expectation
  initial begin
    rgb_t want;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid && out_chan.ready) begin
        if (pending_colors.size() == 0) begin
          $error("unexpected color %0h %0h %0h", out_chan.red_out, out_chan.green_out,
                 out_chan.blue_out);
          fail_count++;
        end else begin
          want = pending_colors.pop_front();
          colors_checked++;
          if (want.red != out_chan.red_out) begin
            $error("red_out: expected %0h, got %0h", want.red, out_chan.red_out);
            fail_count++;
          end
          if (want.green != out_chan.green_out) begin
            $error("green_out: expected %0h, got %0h", want.green, out_chan.green_out);
            fail_count++;
          end
          if (want.blue != out_chan.blue_out) begin
            $error("blue_out: expected %0h, got %0h", want.blue, out_chan.blue_out);
            fail_count++;
          end
        end
      end
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d colors still owed", stall,
                 pending_colors.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [BANK_W-1:0] mid_bank;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_chan.valid       <= 1'b0;
    in_chan.operation   <= OP_WRITE;
    in_chan.bank        <= '0;
    in_chan.first_index <= '0;
    in_chan.last_index  <= '0;
    in_chan.red_in      <= '0;
    in_chan.green_in    <= '0;
    in_chan.blue_in     <= '0;
    foreach (palette_model[b, e]) palette_model[b][e] = '0;
    active_bank_model = '0;
    request_held      = 1'b0;
    fail_count        = 0;
    requests_sent     = 0;
    rotates_sent      = 0;
    colors_checked    = 0;
    send_idle_pct     = 9;
    recv_idle_pct     = 71;
    window_base       = 0;
    mid_bank          = BANK_W'($urandom_range(1, 6));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_active_bank('0);

    foreach (DIRECTED[i])
      send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].typed_color);

    for (int phase = 0; phase < 3; phase++) begin
      wait_quiet();
      case (phase)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 71;
          write_active_bank('1);
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 9;
          write_active_bank(mid_bank);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_active_bank('0);
        end
      endcase
      // aim most indices at one window so lookups see written and rotated colors
      window_base = (phase == 0) ? 224 : $urandom_range(224);
      repeat (ITEMS_PER_PHASE) send_request(random_request(), 1'b0, '0);
    end
    wait_quiet();

    $display("ran %0d requests (%0d rotates), checked %0d looked-up colors", requests_sent,
             rotates_sent, colors_checked);
    $display("active bank settings 0, 7, %0d under three idle patterns", mid_bank);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
